// File: hdl/bm2t_pkg.sv
// ----------------------------------------------------------------------------
// Block mover package
// Request and command types and status codes shared by the block mover.
// ----------------------------------------------------------------------------
package bm2t_pkg;

    localparam int ADDR_W  = 22;
    localparam int BASE_W  = 20;
    localparam int PITCH_W = 16;
    localparam int DIM_W   = 4;
    localparam int CNT_W   = 10;
    localparam int XFER_W  = 32;
    localparam int TOTAL_W = 40;

    localparam logic [1:0] KIND_L3 = 2'd0;
    localparam logic [1:0] KIND_L2 = 2'd1;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_SRC    = 3'd1;
    localparam logic [2:0] ST_BAD_DST    = 3'd2;
    localparam logic [2:0] ST_NO_SRC_REG = 3'd3;
    localparam logic [2:0] ST_NO_DST_REG = 3'd4;

    typedef struct packed {
        logic [1:0]         src_kind;
        logic [3:0]         src_unit;
        logic [BASE_W-1:0]  src_base;
        logic [PITCH_W-1:0] src_pitch;
        logic [1:0]         dst_kind;
        logic [3:0]         dst_unit;
        logic [BASE_W-1:0]  dst_base;
        logic [PITCH_W-1:0] dst_pitch;
        logic [DIM_W-1:0]   rows;
        logic [DIM_W-1:0]   cols;
        logic [3:0]         elem_bytes;
        logic               flip;
    } bm2t_desc_t;

    typedef struct packed {
        logic [3:0]         read_region;
        logic [ADDR_W-1:0]  read_addr;
        logic [3:0]         write_region;
        logic [ADDR_W-1:0]  write_addr;
        logic [CNT_W-1:0]   byte_count;
        logic               last;
        logic [2:0]         status;
        logic [XFER_W-1:0]  transfers_total;
        logic [TOTAL_W-1:0] bytes_total;
    } bm2t_cmd_t;

endpackage

// File: hdl/block_mover_2d_transpose.sv
// ----------------------------------------------------------------------------
// Two-dimensional block mover with transpose
// Takes one transfer request and issues the copy commands that carry it out.
//
//   Channel   Direction  Handshake               Payload
//   desc      in         desc_valid/desc_stall   bm2t_desc_t
//   cmd       out        cmd_valid/cmd_stall     bm2t_cmd_t
//
// A request passes the check and sizing states, then the address sequencer
// issues one command a cycle while the output is not stalled: one for a
// contiguous block, rows commands when strided, rows*cols when transposed (up
// to MAX_DIM squared), one empty final command for a failed check or no work.
// Reset clears the running totals and the sequencer. A stalled output holds
// the sequencer where it is.
// ----------------------------------------------------------------------------
module block_mover_2d_transpose
    import bm2t_pkg::*;
#(
    parameter int MAX_DIM      = 8,
    parameter int NUM_L3_TILES = 4,
    parameter int NUM_L2_BANKS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       desc_valid,
    output logic       desc_stall,
    input  bm2t_desc_t desc,
    output logic       cmd_valid,
    input  logic       cmd_stall,
    output bm2t_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CHK  = 2'd1;
    localparam logic [1:0] S_CALC = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    localparam logic [2:0] M_ERR    = 3'd0;
    localparam logic [2:0] M_NOWORK = 3'd1;
    localparam logic [2:0] M_SINGLE = 3'd2;
    localparam logic [2:0] M_ROWS   = 3'd3;
    localparam logic [2:0] M_ELEM   = 3'd4;

    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

    logic [1:0]         state_reg, state_next;
    logic [2:0]         mode_reg, mode_next;
    logic [2:0]         status_reg, status_next;
    bm2t_desc_t         d_reg, d_next;
    logic [DIM_W-1:0]   h_reg, h_next, w_reg, w_next;
    logic [7:0]         row_size_reg, row_size_next;
    logic [7:0]         col_bytes_reg, col_bytes_next;
    logic [CNT_W-1:0]   blk_bytes_reg, blk_bytes_next;
    logic [PITCH_W-1:0] ss_reg, ss_next, ds_reg, ds_next;
    logic [DIM_W-1:0]   row_reg, row_next, col_reg, col_next;
    logic [ADDR_W-1:0]  src_row_reg, src_row_next, src_cur_reg, src_cur_next;
    logic [ADDR_W-1:0]  dst_row_reg, dst_row_next, dst_cur_reg, dst_cur_next;
    logic [XFER_W-1:0]  xfer_reg, xfer_next;
    logic [TOTAL_W-1:0] bytes_reg, bytes_next;
    logic               cmd_valid_reg, cmd_valid_next;
    bm2t_cmd_t          cmd_reg, cmd_next;

    bm2t_cmd_t          cur_cmd;
    logic               row_last, col_last, cmd_last, slot_free;
    logic [PITCH_W-1:0] ss_calc, ds_calc;

    function automatic logic region_ok(input logic [1:0] kind, input logic [3:0] region);
        logic ok;
        if (kind == KIND_L3)
        begin
            ok = {1'b0, region} < 5'(NUM_L3_TILES);
        end
        else
        begin
            ok = {1'b0, region} < 5'(NUM_L2_BANKS);
        end
        return ok;
    endfunction

    assign desc_stall = (state_reg != S_IDLE);
    assign cmd_valid  = cmd_valid_reg;
    assign cmd        = cmd_reg;
    assign slot_free  = !cmd_valid_reg || !cmd_stall;

    assign row_last = (row_reg == h_reg - 4'd1);
    assign col_last = (col_reg == w_reg - 4'd1);

    always_comb
    begin
        unique case (mode_reg)
            M_ROWS:  cmd_last = row_last;
            M_ELEM:  cmd_last = row_last && col_last;
            default: cmd_last = 1'b1;
        endcase

        cur_cmd.read_region  = d_reg.src_unit;
        cur_cmd.read_addr    = src_cur_reg;
        cur_cmd.write_region = d_reg.dst_unit;
        cur_cmd.write_addr   = dst_cur_reg;
        cur_cmd.last         = cmd_last;
        cur_cmd.status       = status_reg;
        cur_cmd.transfers_total = cmd_last ? xfer_reg : '0;
        cur_cmd.bytes_total     = cmd_last ? bytes_reg : '0;
        unique case (mode_reg)
            M_SINGLE: cur_cmd.byte_count = blk_bytes_reg;
            M_ROWS:   cur_cmd.byte_count = {2'b00, row_size_reg};
            M_ELEM:   cur_cmd.byte_count = {6'b000000, d_reg.elem_bytes};
            default:  cur_cmd.byte_count = '0;
        endcase
        if (mode_reg == M_ERR)
        begin
            cur_cmd.read_region  = '0;
            cur_cmd.read_addr    = '0;
            cur_cmd.write_region = '0;
            cur_cmd.write_addr   = '0;
        end
    end

    always_comb
    begin
        ss_calc = (d_reg.src_pitch != '0) ? d_reg.src_pitch : {8'h00, row_size_reg};
        if (d_reg.dst_pitch != '0)
        begin
            ds_calc = d_reg.dst_pitch;
        end
        else if (d_reg.flip)
        begin
            ds_calc = {8'h00, col_bytes_reg};
        end
        else
        begin
            ds_calc = {8'h00, row_size_reg};
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        status_next    = status_reg;
        d_next         = d_reg;
        h_next         = h_reg;
        w_next         = w_reg;
        row_size_next  = row_size_reg;
        col_bytes_next = col_bytes_reg;
        blk_bytes_next = blk_bytes_reg;
        ss_next        = ss_reg;
        ds_next        = ds_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        src_row_next   = src_row_reg;
        src_cur_next   = src_cur_reg;
        dst_row_next   = dst_row_reg;
        dst_cur_next   = dst_cur_reg;
        xfer_next      = xfer_reg;
        bytes_next     = bytes_reg;
        cmd_valid_next = cmd_valid_reg;
        cmd_next       = cmd_reg;

        if (slot_free)
        begin
            cmd_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (desc_valid)
                begin
                    d_next     = desc;
                    h_next     = (desc.rows > DIM_MAX) ? DIM_MAX : desc.rows;
                    w_next     = (desc.cols > DIM_MAX) ? DIM_MAX : desc.cols;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                priority if (d_reg.src_kind > KIND_L2)
                    status_next = ST_BAD_SRC;
                else if (d_reg.dst_kind > KIND_L2)
                    status_next = ST_BAD_DST;
                else if (!region_ok(d_reg.src_kind, d_reg.src_unit))
                    status_next = ST_NO_SRC_REG;
                else if (!region_ok(d_reg.dst_kind, d_reg.dst_unit))
                    status_next = ST_NO_DST_REG;
                else
                    status_next = ST_OK;
                row_size_next  = {4'h0, w_reg} * {4'h0, d_reg.elem_bytes};
                col_bytes_next = {4'h0, h_reg} * {4'h0, d_reg.elem_bytes};
                state_next     = S_CALC;
            end
            S_CALC:
            begin
                blk_bytes_next = CNT_W'({8'h00, h_reg} * {4'h0, row_size_reg});
                ss_next        = ss_calc;
                ds_next        = ds_calc;
                row_next       = '0;
                col_next       = '0;
                src_row_next   = ADDR_W'(d_reg.src_base);
                src_cur_next   = ADDR_W'(d_reg.src_base);
                dst_row_next   = ADDR_W'(d_reg.dst_base);
                dst_cur_next   = ADDR_W'(d_reg.dst_base);
                priority if (status_reg != ST_OK)
                    mode_next = M_ERR;
                else if (h_reg == '0 || w_reg == '0 || d_reg.elem_bytes == '0)
                    mode_next = M_NOWORK;
                else if (d_reg.flip)
                    mode_next = M_ELEM;
                else if (ss_calc == {8'h00, row_size_reg} &&
                         ds_calc == {8'h00, row_size_reg})
                    mode_next = M_SINGLE;
                else
                    mode_next = M_ROWS;
                if (status_reg == ST_OK && h_reg != '0 && w_reg != '0 &&
                    d_reg.elem_bytes != '0)
                begin
                    xfer_next  = xfer_reg + 32'd1;
                    bytes_next = bytes_reg +
                                 TOTAL_W'(CNT_W'({8'h00, h_reg} * {4'h0, row_size_reg}));
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    cmd_next       = cur_cmd;
                    cmd_valid_next = 1'b1;
                    if (cmd_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (mode_reg == M_ROWS)
                    begin
                        row_next     = row_reg + 4'd1;
                        src_cur_next = src_cur_reg + ADDR_W'(ss_reg);
                        dst_cur_next = dst_cur_reg + ADDR_W'(ds_reg);
                    end
                    else if (col_last)
                    begin
                        row_next     = row_reg + 4'd1;
                        col_next     = '0;
                        src_row_next = src_row_reg + ADDR_W'(ss_reg);
                        src_cur_next = src_row_reg + ADDR_W'(ss_reg);
                        dst_row_next = dst_row_reg + ADDR_W'(d_reg.elem_bytes);
                        dst_cur_next = dst_row_reg + ADDR_W'(d_reg.elem_bytes);
                    end
                    else
                    begin
                        col_next     = col_reg + 4'd1;
                        src_cur_next = src_cur_reg + ADDR_W'(d_reg.elem_bytes);
                        dst_cur_next = dst_cur_reg + ADDR_W'(ds_reg);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= M_ERR;
            row_reg       <= '0;
            col_reg       <= '0;
            xfer_reg      <= '0;
            bytes_reg     <= '0;
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            xfer_reg      <= xfer_next;
            bytes_reg     <= bytes_next;
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        d_reg         <= d_next;
        h_reg         <= h_next;
        w_reg         <= w_next;
        row_size_reg  <= row_size_next;
        col_bytes_reg <= col_bytes_next;
        blk_bytes_reg <= blk_bytes_next;
        ss_reg        <= ss_next;
        ds_reg        <= ds_next;
        src_row_reg   <= src_row_next;
        src_cur_reg   <= src_cur_next;
        dst_row_reg   <= dst_row_next;
        dst_cur_reg   <= dst_cur_next;
        cmd_reg       <= cmd_next;
    end

    // A failed check must come out as a single empty final command.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd.status != ST_OK |-> cmd.last && cmd.byte_count == '0)
        else $error("error command is not an empty final command");

    // The running totals move only in the cycle that sizes a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(xfer_reg) |-> $past(state_reg) == S_CALC)
        else $error("transfer count changed outside the sizing step");

    // The walk never runs past the block height or width.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT && (mode_reg == M_ROWS || mode_reg == M_ELEM)
        |-> row_reg < h_reg && col_reg < w_reg)
        else $error("walk position outside the block");

endmodule

// File: tb/bm2t_cmd_checker.sv
// ----------------------------------------------------------------------------
// Block mover command checker
// Watches the request and command channels of the block mover. For every
// request that is taken, it works out the copy commands due and queues them.
// Every command that is taken is compared field by field with the oldest
// queued command. Failures are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bm2t_cmd_checker
    import bm2t_pkg::*;
#(
    parameter int MAX_DIM      = 8,
    parameter int NUM_L3_TILES = 4,
    parameter int NUM_L2_BANKS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       desc_valid,
    input  logic       desc_stall,
    input  bm2t_desc_t desc,
    input  logic       cmd_valid,
    input  logic       cmd_stall,
    input  bm2t_cmd_t  cmd,
    output int         error_count,
    output int         pending
);

    bm2t_cmd_t          expected_cmds[$];
    logic [XFER_W-1:0]  xfer_total;
    logic [TOTAL_W-1:0] byte_total;

    function automatic bit region_valid(input logic [1:0] kind, input logic [3:0] region);
        if (kind == KIND_L3)
        begin
            return region < NUM_L3_TILES;
        end
        return region < NUM_L2_BANKS;
    endfunction

    task automatic push_command(input bm2t_desc_t d, input int rd_addr, input int wr_addr,
                                input int bytes, input bit is_last);
        bm2t_cmd_t c;
        c = '0;
        c.read_region  = d.src_unit;
        c.read_addr    = ADDR_W'(rd_addr);
        c.write_region = d.dst_unit;
        c.write_addr   = ADDR_W'(wr_addr);
        c.byte_count   = CNT_W'(bytes);
        c.last         = is_last;
        c.status       = ST_OK;
        if (is_last)
        begin
            c.transfers_total = xfer_total;
            c.bytes_total     = byte_total;
        end
        expected_cmds.push_back(c);
    endtask

    task automatic queue_commands(input bm2t_desc_t d);
        bm2t_cmd_t  c;
        logic [2:0] st;
        int         h;
        int         w;
        int         e;
        int         sb;
        int         db;
        int         row_size;
        int         src_step;
        int         dst_step;
        st = ST_OK;
        if (d.src_kind > KIND_L2)
        begin
            st = ST_BAD_SRC;
        end
        else if (d.dst_kind > KIND_L2)
        begin
            st = ST_BAD_DST;
        end
        else if (!region_valid(d.src_kind, d.src_unit))
        begin
            st = ST_NO_SRC_REG;
        end
        else if (!region_valid(d.dst_kind, d.dst_unit))
        begin
            st = ST_NO_DST_REG;
        end
        h  = (d.rows > MAX_DIM) ? MAX_DIM : int'(d.rows);
        w  = (d.cols > MAX_DIM) ? MAX_DIM : int'(d.cols);
        e  = int'(d.elem_bytes);
        sb = int'(d.src_base);
        db = int'(d.dst_base);
        if (st != ST_OK)
        begin
            c = '0;
            c.last            = 1'b1;
            c.status          = st;
            c.transfers_total = xfer_total;
            c.bytes_total     = byte_total;
            expected_cmds.push_back(c);
        end
        else if (h == 0 || w == 0 || e == 0)
        begin
            // A request with nothing to move still reports the running totals.
            push_command(d, sb, db, 0, 1'b1);
        end
        else
        begin
            xfer_total = xfer_total + 1'b1;
            byte_total = byte_total + TOTAL_W'(h * w * e);
            row_size   = w * e;
            src_step   = (d.src_pitch != 0) ? int'(d.src_pitch) : row_size;
            if (d.flip)
            begin
                dst_step = (d.dst_pitch != 0) ? int'(d.dst_pitch) : h * e;
                for (int r = 0; r < h; r++)
                begin
                    for (int k = 0; k < w; k++)
                    begin
                        push_command(d, sb + r * src_step + k * e, db + k * dst_step + r * e,
                                     e, (r == h - 1) && (k == w - 1));
                    end
                end
            end
            else
            begin
                dst_step = (d.dst_pitch != 0) ? int'(d.dst_pitch) : row_size;
                if (src_step == row_size && dst_step == row_size)
                begin
                    push_command(d, sb, db, h * row_size, 1'b1);
                end
                else
                begin
                    for (int r = 0; r < h; r++)
                    begin
                        push_command(d, sb + r * src_step, db + r * dst_step, row_size,
                                     r == h - 1);
                    end
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    task automatic check_command(input bm2t_cmd_t c);
        bm2t_cmd_t want;
        if (expected_cmds.size() == 0)
        begin
            $error("command 0x%0h issued with none expected", c);
            error_count++;
        end
        else
        begin
            want = expected_cmds.pop_front();
            check_field("read_region", want.read_region, c.read_region);
            check_field("read_addr", want.read_addr, c.read_addr);
            check_field("write_region", want.write_region, c.write_region);
            check_field("write_addr", want.write_addr, c.write_addr);
            check_field("byte_count", want.byte_count, c.byte_count);
            check_field("last", want.last, c.last);
            check_field("status", want.status, c.status);
            check_field("transfers_total", want.transfers_total, c.transfers_total);
            check_field("bytes_total", want.bytes_total, c.bytes_total);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xfer_total = '0;
            byte_total = '0;
            expected_cmds.delete();
            pending <= 0;
        end
        else
        begin
            if (desc_valid && !desc_stall)
            begin
                queue_commands(desc);
            end
            if (cmd_valid && !cmd_stall)
            begin
                check_command(cmd);
            end
            pending <= expected_cmds.size();
        end
    end

endmodule

// File: tb/tb_block_mover_2d_transpose.sv
// ----------------------------------------------------------------------------
// Block mover testbench
// Drives directed and random transfer requests into the block mover with
// random gaps on the request side and random stalls on the command side,
// including a long command hold-off and a full drain part-way through.
// A separate checker predicts and compares every command.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_block_mover_2d_transpose;
    import bm2t_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int MAX_DIM         = 8;
    localparam int NUM_L3_TILES    = 4;
    localparam int NUM_L2_BANKS    = 8;
    localparam int RANDOM_ITEMS    = 108;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int TIMEOUT_CYCLES  = 2000000;

    localparam logic [1:0] KIND_RSVD2 = 2'd2;
    localparam logic [1:0] KIND_RSVD3 = 2'd3;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       desc_valid;
    logic       desc_stall;
    bm2t_desc_t desc;
    logic       cmd_valid;
    logic       cmd_stall;
    bm2t_cmd_t  cmd;
    int         error_count;
    int         pending;
    bit         hold_off_req;
    bit         burst;

    always #(CLK_PERIOD / 2) clk = ~clk;

    block_mover_2d_transpose #(
        .MAX_DIM      (MAX_DIM),
        .NUM_L3_TILES (NUM_L3_TILES),
        .NUM_L2_BANKS (NUM_L2_BANKS)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (desc_valid),
        .desc_stall (desc_stall),
        .desc       (desc),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd)
    );

    bm2t_cmd_checker #(
        .MAX_DIM      (MAX_DIM),
        .NUM_L3_TILES (NUM_L3_TILES),
        .NUM_L2_BANKS (NUM_L2_BANKS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .desc_valid  (desc_valid),
        .desc_stall  (desc_stall),
        .desc        (desc),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .error_count (error_count),
        .pending     (pending)
    );

    function automatic bm2t_desc_t desc_of(
        input logic [1:0] sk, input int sr, input int sb, input int sp,
        input logic [1:0] dk, input int dr, input int db, input int dp,
        input int h, input int w, input int e, input bit fl);
        bm2t_desc_t d;
        d.src_kind   = sk;
        d.src_unit   = 4'(sr);
        d.src_base   = BASE_W'(sb);
        d.src_pitch  = PITCH_W'(sp);
        d.dst_kind   = dk;
        d.dst_unit   = 4'(dr);
        d.dst_base   = BASE_W'(db);
        d.dst_pitch  = PITCH_W'(dp);
        d.rows       = DIM_W'(h);
        d.cols       = DIM_W'(w);
        d.elem_bytes = 4'(e);
        d.flip       = fl;
        return d;
    endfunction

    function automatic int pitch_for(input int natural);
        case ($urandom_range(0, 3))
            0: return 0;
            1: return natural;
            2: return natural + $urandom_range(1, 64);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    task automatic send(input bm2t_desc_t d);
        int gap;
        int pick;
        desc       <= d;
        desc_valid <= 1'b1;
        do
            @(posedge clk);
        while (desc_stall);
        pick = $urandom_range(0, 19);
        if (burst || pick < 10)
        begin
            gap = 0;
        end
        else if (pick < 18)
        begin
            gap = $urandom_range(1, 4);
        end
        else
        begin
            gap = $urandom_range(20, 60);
        end
        if (gap > 0)
        begin
            desc_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_for_drain();
        int waited;
        waited = 0;
        desc_valid <= 1'b0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (pending != 0 && waited < DRAIN_LIMIT);
    endtask

    initial
    begin : cmd_stall_gen
        int  run;
        int  pick;
        bit  stall;
        cmd_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall = 1'b1;
                run   = HOLD_OFF_CYCLES;
            end
            else
            begin
                pick = $urandom_range(0, 19);
                stall = (pick >= 10);
                if (pick < 8)
                begin
                    run = $urandom_range(1, 6);
                end
                else if (pick < 10)
                begin
                    run = $urandom_range(30, 80);
                end
                else if (pick < 18)
                begin
                    run = $urandom_range(1, 3);
                end
                else
                begin
                    run = $urandom_range(10, 30);
                end
            end
            cmd_stall <= stall;
            repeat (run) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        bm2t_desc_t   d;
        logic [127:0] noise;
        int           h;
        int           w;
        int           e;
        desc_valid <= 1'b0;
        desc       <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(desc_of(KIND_L3, 0, 0, 0, KIND_L2, 7, 0, 0, 8, 8, 8, 1'b0));
        send(desc_of(KIND_L2, 3, 'h12345, 16, KIND_L3, 1, 'h100, 16, 4, 4, 4, 1'b0));
        send(desc_of(KIND_L2, 7, 'hFFFFF, 'hFFFF, KIND_L2, 0, 'hFFFFF, 0, 8, 3, 2, 1'b0));
        send(desc_of(KIND_L3, 3, 5, 0, KIND_L3, 2, 7, 'hFFFF, 2, 8, 8, 1'b0));
        send(desc_of(KIND_L3, 1, 0, 0, KIND_L2, 5, 'h400, 0, 8, 8, 8, 1'b1));
        send(desc_of(KIND_L2, 6, 'h800, 100, KIND_L3, 0, 'h10, 'hFFFF, 3, 5, 4, 1'b1));
        send(desc_of(KIND_L3, 0, 0, 0, KIND_L3, 0, 0, 0, 1, 1, 1, 1'b1));
        send(desc_of(KIND_L2, 4, 'hABCDE, 0, KIND_L2, 4, 'h54321, 0, 1, 1, 1, 1'b0));
        send(desc_of(KIND_RSVD2, 0, 1, 2, KIND_L3, 0, 3, 4, 2, 2, 2, 1'b0));
        send(desc_of(KIND_RSVD3, 15, 1, 2, KIND_RSVD3, 15, 3, 4, 2, 2, 2, 1'b1));
        send(desc_of(KIND_L3, 9, 1, 2, KIND_RSVD2, 0, 3, 4, 2, 2, 2, 1'b0));
        send(desc_of(KIND_L2, 0, 1, 2, KIND_RSVD3, 0, 3, 4, 2, 2, 2, 1'b0));
        send(desc_of(KIND_L3, 4, 1, 2, KIND_L2, 0, 3, 4, 2, 2, 2, 1'b0));
        send(desc_of(KIND_L2, 15, 1, 2, KIND_L3, 12, 3, 4, 2, 2, 2, 1'b1));
        send(desc_of(KIND_L2, 7, 1, 2, KIND_L3, 4, 3, 4, 2, 2, 2, 1'b0));
        send(desc_of(KIND_L3, 3, 1, 2, KIND_L2, 8, 3, 4, 2, 2, 2, 1'b1));
        send(desc_of(KIND_L3, 2, 'h777, 8, KIND_L2, 2, 'h999, 8, 0, 4, 2, 1'b0));
        send(desc_of(KIND_L2, 2, 'h777, 8, KIND_L3, 2, 'h999, 8, 4, 0, 2, 1'b1));
        send(desc_of(KIND_L2, 1, 'h777, 8, KIND_L2, 3, 'h999, 8, 4, 4, 0, 1'b0));
        send(desc_of(KIND_L3, 1, 'h20, 0, KIND_L2, 6, 'h40, 0, 15, 15, 15, 1'b0));
        send(desc_of(KIND_L2, 5, 'h3000, 0, KIND_L3, 2, 'h6000, 0, 9, 12, 15, 1'b1));
        send(desc_of(KIND_L3, 0, 'hFFF00, 3, KIND_L3, 3, 'h80, 0, 15, 1, 9, 1'b0));

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 40)
            begin
                wait_for_drain();
            end
            if (i == 80)
            begin
                hold_off_req = 1'b1;
                burst        = 1'b1;
            end
            if (i == 95)
            begin
                burst = 1'b0;
            end
            if ($urandom_range(0, 99) < 75)
            begin
                d.src_kind   = $urandom_range(0, 1) ? KIND_L2 : KIND_L3;
                d.dst_kind   = $urandom_range(0, 1) ? KIND_L2 : KIND_L3;
                d.src_unit   = 4'($urandom_range(0, (d.src_kind == KIND_L3) ?
                                                    NUM_L3_TILES - 1 : NUM_L2_BANKS - 1));
                d.dst_unit   = 4'($urandom_range(0, (d.dst_kind == KIND_L3) ?
                                                    NUM_L3_TILES - 1 : NUM_L2_BANKS - 1));
                d.src_base   = BASE_W'($urandom());
                d.dst_base   = BASE_W'($urandom());
                d.flip       = 1'($urandom_range(0, 1));
                h = $urandom_range(1, $urandom_range(1, MAX_DIM));
                w = $urandom_range(1, $urandom_range(1, MAX_DIM));
                e = $urandom_range(1, 8);
                if ($urandom_range(0, 9) == 0)
                begin
                    h = $urandom_range(0, 15);
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    w = $urandom_range(0, 15);
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    e = $urandom_range(0, 15);
                end
                d.rows       = DIM_W'(h);
                d.cols       = DIM_W'(w);
                d.elem_bytes = 4'(e);
                d.src_pitch  = PITCH_W'(pitch_for(w * e));
                d.dst_pitch  = PITCH_W'(pitch_for(d.flip ? h * e : w * e));
            end
            else
            begin
                noise = {$urandom(), $urandom(), $urandom(), $urandom()};
                d = noise[$bits(bm2t_desc_t)-1:0];
            end
            send(d);
        end

        wait_for_drain();
        repeat (20) @(posedge clk);
        if (pending != 0)
        begin
            $error("%0d expected commands never issued", pending);
        end
        if (error_count == 0 && pending == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial
    begin : watchdog
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
